// ===== src/a2m_pkg.sv =====
// ----------------------------------------------------------------------------
// a2m_pkg
// Shared types, constants and the character-to-element lookup for the
// ASCII to Morse keying serializer.
// ----------------------------------------------------------------------------
package a2m_pkg;

  // Longest sequence: five dashes (5 x 4 bits) plus the 2-bit gap.
  localparam int MAX_BITS = 22;
  localparam int LEN_W    = $clog2(MAX_BITS + 1);
  localparam int MAX_ELEM = 5;

  localparam int DOT_BITS  = 2;
  localparam int DASH_BITS = 4;
  localparam int GAP_BITS  = 2;

  localparam logic [MAX_BITS-1:0] DOT_PAT  = MAX_BITS'('h01);
  localparam logic [MAX_BITS-1:0] DASH_PAT = MAX_BITS'('h07);

  // Element codes
  localparam logic [1:0] EL_END  = 2'd0;
  localparam logic [1:0] EL_DOT  = 2'd1;
  localparam logic [1:0] EL_DASH = 2'd2;

  // Five element codes, element 0 in the low bits
  typedef logic [2*MAX_ELEM-1:0] elems_t;

  // Encoded character handed to the serializer
  typedef struct packed {
    logic [MAX_BITS-1:0] pattern;  // keying bits, first bit in bit 0
    logic [LEN_W-1:0]    len;      // number of result bits
    logic                bad;      // unsupported character
  } enc_t;

  function automatic elems_t mk(input logic [1:0] e0, input logic [1:0] e1,
                                input logic [1:0] e2, input logic [1:0] e3,
                                input logic [1:0] e4);
    return {e4, e3, e2, e1, e0};
  endfunction

  // Element list of an uppercase letter or digit; all-end for anything else
  function automatic elems_t char_elems(input logic [7:0] c);
    elems_t e;
    e = '0;
    case (c)
      "A": e = mk(EL_DOT,  EL_DASH, EL_END,  EL_END,  EL_END);
      "B": e = mk(EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_END);
      "C": e = mk(EL_DASH, EL_DOT,  EL_DASH, EL_DOT,  EL_END);
      "D": e = mk(EL_DASH, EL_DOT,  EL_DOT,  EL_END,  EL_END);
      "E": e = mk(EL_DOT,  EL_END,  EL_END,  EL_END,  EL_END);
      "F": e = mk(EL_DOT,  EL_DOT,  EL_DASH, EL_DOT,  EL_END);
      "G": e = mk(EL_DASH, EL_DASH, EL_DOT,  EL_END,  EL_END);
      "H": e = mk(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_END);
      "I": e = mk(EL_DOT,  EL_DOT,  EL_END,  EL_END,  EL_END);
      "J": e = mk(EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_END);
      "K": e = mk(EL_DASH, EL_DOT,  EL_DASH, EL_END,  EL_END);
      "L": e = mk(EL_DOT,  EL_DASH, EL_DOT,  EL_DOT,  EL_END);
      "M": e = mk(EL_DASH, EL_DASH, EL_END,  EL_END,  EL_END);
      "N": e = mk(EL_DASH, EL_DOT,  EL_END,  EL_END,  EL_END);
      "O": e = mk(EL_DASH, EL_DASH, EL_DASH, EL_END,  EL_END);
      "P": e = mk(EL_DOT,  EL_DASH, EL_DASH, EL_DOT,  EL_END);
      "Q": e = mk(EL_DASH, EL_DASH, EL_DOT,  EL_DASH, EL_END);
      "R": e = mk(EL_DOT,  EL_DASH, EL_DOT,  EL_END,  EL_END);
      "S": e = mk(EL_DOT,  EL_DOT,  EL_DOT,  EL_END,  EL_END);
      "T": e = mk(EL_DASH, EL_END,  EL_END,  EL_END,  EL_END);
      "U": e = mk(EL_DOT,  EL_DOT,  EL_DASH, EL_END,  EL_END);
      "V": e = mk(EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_END);
      "W": e = mk(EL_DOT,  EL_DASH, EL_DASH, EL_END,  EL_END);
      "X": e = mk(EL_DASH, EL_DOT,  EL_DOT,  EL_DASH, EL_END);
      "Y": e = mk(EL_DASH, EL_DOT,  EL_DASH, EL_DASH, EL_END);
      "Z": e = mk(EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_END);
      "0": e = mk(EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_DASH);
      "1": e = mk(EL_DOT,  EL_DASH, EL_DASH, EL_DASH, EL_DASH);
      "2": e = mk(EL_DOT,  EL_DOT,  EL_DASH, EL_DASH, EL_DASH);
      "3": e = mk(EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH, EL_DASH);
      "4": e = mk(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DASH);
      "5": e = mk(EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT);
      "6": e = mk(EL_DASH, EL_DOT,  EL_DOT,  EL_DOT,  EL_DOT);
      "7": e = mk(EL_DASH, EL_DASH, EL_DOT,  EL_DOT,  EL_DOT);
      "8": e = mk(EL_DASH, EL_DASH, EL_DASH, EL_DOT,  EL_DOT);
      "9": e = mk(EL_DASH, EL_DASH, EL_DASH, EL_DASH, EL_DOT);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ===== src/a2m_encoder.sv =====
// ----------------------------------------------------------------------------
// a2m_encoder
// Combinational encoder: ASCII code to keying bit pattern and length.
// ----------------------------------------------------------------------------
module a2m_encoder (
  input  logic [7:0]     char_code,
  output a2m_pkg::enc_t  enc
);

  a2m_pkg::elems_t                elems;
  logic                           is_sym;
  logic                           is_space;
  logic [a2m_pkg::LEN_W-1:0]      pos;
  logic [a2m_pkg::MAX_BITS-1:0]   pat;
  logic [1:0]                     el;

  always_comb begin
    elems    = a2m_pkg::char_elems(char_code);
    is_space = (char_code == " ");
    is_sym   = ((char_code >= "A") && (char_code <= "Z")) ||
               ((char_code >= "0") && (char_code <= "9"));

    // Lay elements out back to back; trailing end codes add nothing
    pos = '0;
    pat = '0;
    for (int i = 0; i < a2m_pkg::MAX_ELEM; i++) begin
      el = elems[2*i +: 2];
      if (el == a2m_pkg::EL_DOT) begin
        pat = pat | (a2m_pkg::DOT_PAT << pos);
        pos = pos + a2m_pkg::LEN_W'(a2m_pkg::DOT_BITS);
      end else if (el == a2m_pkg::EL_DASH) begin
        pat = pat | (a2m_pkg::DASH_PAT << pos);
        pos = pos + a2m_pkg::LEN_W'(a2m_pkg::DASH_BITS);
      end
    end

    if (is_sym || is_space) begin
      enc.pattern = pat;  // gap bits are zero already
      enc.len     = pos + a2m_pkg::LEN_W'(a2m_pkg::GAP_BITS);
      enc.bad     = 1'b0;
    end else begin
      // unsupported: one silent bit flagged bad
      enc.pattern = '0;
      enc.len     = a2m_pkg::LEN_W'(1);
      enc.bad     = 1'b1;
    end
  end

endmodule

// ===== src/a2m_shifter.sv =====
// ----------------------------------------------------------------------------
// a2m_shifter
// Result register: shifts one keying bit out per output transfer.
// ----------------------------------------------------------------------------
module a2m_shifter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  a2m_pkg::enc_t        enc,
  input  logic                 fin,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 key_bit,
  output logic                 char_done,
  output logic                 message_done,
  output logic                 bad_char
);

  logic [a2m_pkg::MAX_BITS-1:0] pat_r, pat_nxt;
  logic [a2m_pkg::LEN_W-1:0]    left_r, left_nxt;
  logic                         fin_r, fin_nxt;
  logic                         bad_r, bad_nxt;
  logic                         last;

  assign last         = (left_r == a2m_pkg::LEN_W'(1));
  assign out_valid    = (left_r != '0);
  assign can_load     = (left_r == '0) || (last && out_ready);
  assign key_bit      = pat_r[0];
  assign char_done    = last;
  assign message_done = last && fin_r;
  assign bad_char     = bad_r;

  always_comb begin
    pat_nxt  = pat_r;
    left_nxt = left_r;
    fin_nxt  = fin_r;
    bad_nxt  = bad_r;
    if (load) begin
      pat_nxt  = enc.pattern;
      left_nxt = enc.len;
      fin_nxt  = fin;
      bad_nxt  = enc.bad;
    end else if (out_valid && out_ready) begin
      pat_nxt  = pat_r >> 1;
      left_nxt = left_r - a2m_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
    fin_r <= fin_nxt;
    bad_r <= bad_nxt;
  end

endmodule

// ===== src/ascii_to_morse_bit_serializer.sv =====
// ----------------------------------------------------------------------------
// ascii_to_morse_bit_serializer
// ASCII character in, Morse keying bits out, one bit per result transfer.
// ----------------------------------------------------------------------------
// The first keying bit is offered the cycle after the input transfer.
// Each character sends all of its keying bits (2..22 bits, 1 for an
//   unsupported code); the shifter sends one per cycle while out_ready is high.
// The next character is taken in the cycle its predecessor's last bit leaves.
// Reset (rst_n low, synchronous) empties the shift register; nothing else.
// ----------------------------------------------------------------------------
module ascii_to_morse_bit_serializer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_final_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_key_bit,
  output logic       out_char_done,
  output logic       out_message_done,
  output logic       out_bad_char
);

  a2m_pkg::enc_t enc;
  logic          load;

  // Lookup: character to element pattern, laid out as dot 10 / dash 1110,
  // followed by a two-bit silent gap. Space is the gap alone.
  a2m_encoder u_enc (
    .char_code (in_char_code),
    .enc       (enc)
  );

  // A transfer loads the whole pattern at once; the shifter then drains it.
  // in_ready is high when the shifter is empty or its last bit is leaving,
  // so characters follow each other with no idle bit between them.
  assign load = in_valid && in_ready;

  a2m_shifter u_shift (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .enc          (enc),
    .fin          (in_final_char),
    .can_load     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_bit      (out_key_bit),
    .char_done    (out_char_done),
    .message_done (out_message_done),
    .bad_char     (out_bad_char)
  );

endmodule

// ===== src/a2m_checker.sv =====
// ----------------------------------------------------------------------------
// a2m_checker
// Port-level checks for the Morse keying serializer.
// ----------------------------------------------------------------------------
module a2m_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_key_bit,
  input logic out_char_done,
  input logic out_message_done,
  input logic out_bad_char
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a new character only enters when the current one is finishing
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || (out_char_done && out_ready)))
    else $error("input transfer while character still sending");

  // the last bit of any character is silent
  a_last_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_char_done) |-> !out_key_bit)
    else $error("tone on last bit");

  // bad code is a single bit that ends the character
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_char) |-> out_char_done)
    else $error("bad character spans several bits");

  // message end only on a character end
  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_message_done) |-> out_char_done)
    else $error("message done without character done");

endmodule

bind ascii_to_morse_bit_serializer a2m_checker u_a2m_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_key_bit      (out_key_bit),
  .out_char_done    (out_char_done),
  .out_message_done (out_message_done),
  .out_bad_char     (out_bad_char)
);

// ===== sim/ascii_to_morse_bit_serializer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_to_morse_bit_serializer_tb
// Self-checking bench for the ASCII to Morse keying serializer. A directed
// list covers letters, digits, space, the longest sequence, Q and the codes on
// both sides of each supported range. Random messages with a little noise
// follow. A small tracker builds the expected keying bits of every character
// transfer and checks each bit transfer in order. Both sides idle at random,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module ascii_to_morse_bit_serializer_tb;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_CHARS   = 150;
  localparam int MAX_IDLE       = 8;
  // A stretch this long fills the one character the block holds, so the
  // sender sees in_ready low for most of it.
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AFTER_BITS = 500;
  localparam int DRAIN_CYCLES   = 30;
  localparam int CYCLE_LIMIT    = 400000;

  // One keying bit as the block reports it.
  typedef struct packed {
    logic key;
    logic cdone;
    logic mdone;
    logic bad;
  } key_bit_t;

  // Turns accepted characters into their keying bits and checks the
  // bits that come out against them, oldest first.
  class keying_tracker;
    // Dot/dash spelling; '.' is sent as 1,0 and '-' as 1,1,1,0.
    string letter_code[26] = '{
      ".-",   "-...", "-.-.", "-..",  ".",    "..-.", "--.",  "....", "..",
      ".---", "-.-",  ".-..", "--",   "-.",   "---",  ".--.", "--.-", ".-.",
      "...",  "-",    "..-",  "...-", ".--",  "-..-", "-.--", "--.."
    };
    string digit_code[10] = '{
      "-----", ".----", "..---", "...--", "....-",
      ".....", "-....", "--...", "---..", "----."
    };
    key_bit_t key_queue[$];
    int errors;
    int bits_checked;
    int letters;
    int digits;
    int spaces;
    int bad_chars;
    int finals;

    function void push_key(logic k);
      key_bit_t b;
      b = '{key: k, cdone: 1'b0, mdone: 1'b0, bad: 1'b0};
      key_queue.push_back(b);
    endfunction

    function void add_char(logic [7:0] c, logic fin);
      string spell;
      key_bit_t last;
      if (fin) finals++;
      if (c inside {["A":"Z"]}) begin
        spell = letter_code[int'(c) - int'("A")];
        letters++;
      end else if (c inside {["0":"9"]}) begin
        spell = digit_code[int'(c) - int'("0")];
        digits++;
      end else if (c == " ") begin
        spell = "";
        spaces++;
      end else begin
        // unsupported: a single silent bit carrying the flag
        last = '{key: 1'b0, cdone: 1'b1, mdone: fin, bad: 1'b1};
        key_queue.push_back(last);
        bad_chars++;
        return;
      end
      for (int i = 0; i < spell.len(); i++) begin
        push_key(1'b1);
        if (spell[i] == "-") begin
          push_key(1'b1);
          push_key(1'b1);
        end
        push_key(1'b0);
      end
      // character gap; its second bit closes the character
      push_key(1'b0);
      last = '{key: 1'b0, cdone: 1'b1, mdone: fin, bad: 1'b0};
      key_queue.push_back(last);
    endfunction

    function void compare_field(string name, logic exp_v, logic got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %0b, got %0b", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_key_bit(logic key, logic cdone, logic mdone, logic bad);
      key_bit_t exp_b;
      if (key_queue.size() == 0) begin
        $error("key bit transfer with nothing expected");
        errors++;
        return;
      end
      exp_b = key_queue.pop_front();
      bits_checked++;
      compare_field("key_bit", exp_b.key, key);
      compare_field("char_done", exp_b.cdone, cdone);
      compare_field("message_done", exp_b.mdone, mdone);
      compare_field("bad_char", exp_b.bad, bad);
    endfunction

    function int pending();
      return key_queue.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char_code;
  logic       in_final_char;
  logic       out_valid;
  logic       out_ready;
  logic       out_key_bit;
  logic       out_char_done;
  logic       out_message_done;
  logic       out_bad_char;

  keying_tracker tracker = new();
  // calm = 1 turns off idling on both sides for a stretch of items
  bit calm = 1'b0;
  int cycle_count = 0;
  int hold_cycles = 0;

  ascii_to_morse_bit_serializer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_final_char    (in_final_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_bit      (out_key_bit),
    .out_char_done    (out_char_done),
    .out_message_done (out_message_done),
    .out_bad_char     (out_bad_char)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Both channels are sampled at the rising edge. The character transfer is
  // noted before the bit transfer so a combinational path would still line up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.add_char(in_char_code, in_final_char);
      end
      if (out_valid && out_ready) begin
        tracker.check_key_bit(out_key_bit, out_char_done, out_message_done,
                              out_bad_char);
      end
    end
  end

  // Offer one character. Called and returns at a falling edge; valid stays
  // high straight into the next character when no gap is drawn.
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_char_code  = c;
    in_final_char = fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: draws a stall per bit, and once, after enough bits, holds off
  // for a long stretch while the sender keeps offering characters.
  initial begin : receiver
    int wait_n;
    int bits_rx;
    bit held;
    bit long_now;
    bits_rx  = 0;
    held     = 1'b0;
    long_now = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!held && bits_rx >= HOLD_AFTER_BITS) begin
        wait_n   = LONG_HOLD;
        held     = 1'b1;
        long_now = 1'b1;
      end else begin
        wait_n   = calm ? 0 : $urandom_range(0, MAX_IDLE);
        long_now = 1'b0;
      end
      if (wait_n > 0) begin
        out_ready = 1'b0;
        repeat (wait_n) begin
          @(negedge clk);
          if (long_now) hold_cycles++;
        end
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      bits_rx++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    // Directed: longest sequence (0), Q, single-element letters, space alone,
    // the neighbors of each supported range, lowercase, and both ends of the
    // code range. Every third one closes a message.
    logic [7:0] dir_code[20];
    logic [7:0] c;
    logic       fin;
    int         pick;
    int         left;

    dir_code = '{
      "A", "Q", "0", "5", "E", "T", "Z", "9", " ", "@",
      "[", "/", ":", "a", 8'h00, 8'hFF, 8'h80, 8'h7F, "M", "1"
    };
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_code  = 8'h00;
    in_final_char = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_code[i]) begin
      send_char(dir_code[i], (i % 3) == 2);
    end

    // Random messages: mostly letters and digits with word spaces, some
    // noise codes mixed in; final_char marks the last one of each message.
    left = $urandom_range(1, 8);
    for (int n = 0; n < RANDOM_CHARS; n++) begin
      // every other block of 40 runs with no idling at all
      if (n % 40 == 0) calm = ((n / 40) % 2) == 1;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        c = 8'(int'("A") + $urandom_range(0, 25));
      end else if (pick < 80) begin
        c = 8'(int'("0") + $urandom_range(0, 9));
      end else if (pick < 88) begin
        c = " ";
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      left--;
      fin = (left == 0);
      if (left == 0) left = $urandom_range(1, 8);
      send_char(c, fin);
    end
    in_valid = 1'b0;
    calm     = 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    // a stray extra bit would show up during the drain wait
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d letters, %0d digits, %0d spaces, %0d unsupported codes",
             tracker.letters, tracker.digits, tracker.spaces, tracker.bad_chars);
    $display("%0d message ends, %0d key bits checked, %0d cycles of long hold",
             tracker.finals, tracker.bits_checked, hold_cycles);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
